// ----- design/kufe_pkg.sv -----
`default_nettype none
package kufe_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int COST_BITS    = 32;
    localparam int COST_IN_W    = 32;
    localparam int TOTAL_W      = 48;
    localparam int COUNT_W      = 10;
    localparam int RANK_W       = 4;
    localparam int NV_W         = 11;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [NV_W-1:0]    NV_RESET   = NV_W'(MAX_VERTICES);
    localparam logic [NV_W-1:0]    NV_LIMIT   = NV_W'(MAX_VERTICES);
    localparam logic [RANK_W-1:0]  RANK_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

    // Register word index, taken from paddr above the byte offset.
    localparam logic [APB_ADDR_W-3:0] REG_NUM_VERTICES = '0;

    typedef struct packed {
        logic [VERT_W-1:0] parent;
        logic [RANK_W-1:0] rank;
    } node_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_COMP,
        ST_LINK,
        ST_RANK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- design/kufe_edge_if.sv -----
`default_nettype none
interface kufe_edge_if;
    import kufe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  restart;
    logic [VERT_W-1:0]     from_vertex;
    logic [VERT_W-1:0]     to_vertex;
    logic [COST_IN_W-1:0]  edge_cost;

    modport source (output valid, restart, from_vertex, to_vertex, edge_cost, input ready);
    modport sink (input valid, restart, from_vertex, to_vertex, edge_cost, output ready);
endinterface
`default_nettype wire

// ----- design/kufe_result_if.sv -----
`default_nettype none
interface kufe_result_if;
    import kufe_pkg::*;

    logic                valid;
    logic                ready;
    logic                taken;
    logic                bad_vertex;
    logic [TOTAL_W-1:0]  total_cost;
    logic [COUNT_W-1:0]  tree_edges;

    modport source (output valid, taken, bad_vertex, total_cost, tree_edges, input ready);
    modport sink (input valid, taken, bad_vertex, total_cost, tree_edges, output ready);
endinterface
`default_nettype wire

// ----- design/kruskal_union_find_engine_unit.sv -----
`default_nettype none
// Kruskal spanning-tree engine on a union-find table with union by rank and
// path compression. Edges come in on edge_in, sorted by cost by software, and
// every edge gives exactly one item on result_out: taken, bad_vertex and the
// running total cost and tree-edge count after that edge.
// The table lives in one 1024-entry memory (parent and rank in one word) with
// a registered read port and a separate write port. Each endpoint is found by
// a root walk followed by rewriting of the path behind it. An edge holds the
// engine for both finds plus accept, link and result hand-off, with a rank
// update added when the new root's rank grows. The result is valid the cycle
// after the hand-off. A bad endpoint skips the finds. An edge with restart set
// first runs a clearing pass through the memory. After reset the same clearing
// pass runs before edge_in.ready rises; configuration writes are taken during
// it. One edge is processed at a time. The result sits in an output register,
// and if the receiver stalls the engine holds its finished edge until the
// register frees up. num_vertices lies at APB byte address 0.
module kruskal_union_find_engine_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [kufe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kufe_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kufe_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    kufe_edge_if.sink                           edge_in,
    kufe_result_if.source                       result_out
);
    import kufe_pkg::*;

    state_t state_reg, state_next;

    logic [NV_W-1:0]      num_vertices_reg;
    logic [VERT_W-1:0]    a_reg, a_next;
    logic [VERT_W-1:0]    b_reg, b_next;
    logic [COST_BITS-1:0] cost_reg, cost_next;
    logic                 bad_reg, bad_next;
    logic                 which_reg, which_next;
    logic                 clr_item_reg, clr_item_next;
    logic [VERT_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [VERT_W-1:0]    root_reg, root_next;
    logic [VERT_W-1:0]    cur_reg, cur_next;
    logic [VERT_W-1:0]    ra_reg, ra_next;
    logic [RANK_W-1:0]    rank_a_reg, rank_a_next;
    logic [RANK_W-1:0]    rank_b_reg, rank_b_next;
    logic [VERT_W-1:0]    hi_reg, hi_next;
    logic [RANK_W-1:0]    rank_hi_reg, rank_hi_next;
    logic                 taken_reg, taken_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_taken_reg, out_taken_next;
    logic                 out_bad_reg, out_bad_next;
    logic [TOTAL_W-1:0]   out_total_reg, out_total_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    node_t                mem [MAX_VERTICES];
    node_t                mem_q;
    logic                 mem_re;
    logic [VERT_W-1:0]    mem_raddr;
    logic                 mem_we;
    logic [VERT_W-1:0]    mem_waddr;
    node_t                mem_wdata;

    logic [NV_W-1:0]      limit;
    logic                 in_bad;
    logic [VERT_W-1:0]    vtx;
    logic                 swap;
    logic [TOTAL_W:0]     sum;
    logic                 cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= NV_RESET;
        end
        else if (cfg_write && paddr[APB_ADDR_W-1:2] == REG_NUM_VERTICES)
        begin
            num_vertices_reg <= pwdata[NV_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_NUM_VERTICES)
        begin
            prdata = APB_DATA_W'(num_vertices_reg);
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    assign limit  = (num_vertices_reg > NV_LIMIT) ? NV_LIMIT : num_vertices_reg;
    assign in_bad = ({1'b0, edge_in.from_vertex} >= limit) ||
                    ({1'b0, edge_in.to_vertex} >= limit);
    assign vtx    = which_reg ? b_reg : a_reg;
    assign swap   = rank_a_reg < rank_b_reg;
    assign sum    = {1'b0, total_reg} + (TOTAL_W + 1)'(cost_reg);

    assign edge_in.ready = (state_reg == ST_IDLE);

    assign result_out.valid      = out_valid_reg;
    assign result_out.taken      = out_taken_reg;
    assign result_out.bad_vertex = out_bad_reg;
    assign result_out.total_cost = out_total_reg;
    assign result_out.tree_edges = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            which_reg     <= 1'b0;
            total_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_item_reg  <= clr_item_next;
            which_reg     <= which_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        cost_reg      <= cost_next;
        bad_reg       <= bad_next;
        root_reg      <= root_next;
        cur_reg       <= cur_next;
        ra_reg        <= ra_next;
        rank_a_reg    <= rank_a_next;
        rank_b_reg    <= rank_b_next;
        hi_reg        <= hi_next;
        rank_hi_reg   <= rank_hi_next;
        taken_reg     <= taken_next;
        out_taken_reg <= out_taken_next;
        out_bad_reg   <= out_bad_next;
        out_total_reg <= out_total_next;
        out_count_reg <= out_count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cost_next      = cost_reg;
        bad_next       = bad_reg;
        which_next     = which_reg;
        clr_item_next  = clr_item_reg;
        clr_cnt_next   = clr_cnt_reg;
        root_next      = root_reg;
        cur_next       = cur_reg;
        ra_next        = ra_reg;
        rank_a_next    = rank_a_reg;
        rank_b_next    = rank_b_reg;
        hi_next        = hi_reg;
        rank_hi_next   = rank_hi_reg;
        taken_next     = taken_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_taken_next = out_taken_reg;
        out_bad_next   = out_bad_reg;
        out_total_next = out_total_reg;
        out_count_next = out_count_reg;
        mem_re         = 1'b0;
        mem_raddr      = root_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg;
        mem_wdata      = '{parent: clr_cnt_reg, rank: '0};

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == VERT_W'(MAX_VERTICES - 1))
                begin
                    if (!clr_item_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (bad_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                    clr_item_next = 1'b0;
                end
            end

            ST_IDLE:
            begin
                if (edge_in.valid)
                begin
                    a_next     = edge_in.from_vertex;
                    b_next     = edge_in.to_vertex;
                    cost_next  = edge_in.edge_cost[COST_BITS-1:0];
                    bad_next   = in_bad;
                    which_next = 1'b0;
                    taken_next = 1'b0;
                    if (edge_in.restart)
                    begin
                        total_next    = '0;
                        count_next    = '0;
                        clr_cnt_next  = '0;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else if (in_bad)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end

            ST_START:
            begin
                root_next  = vtx;
                mem_re     = 1'b1;
                mem_raddr  = vtx;
                state_next = ST_WALK;
            end

            // mem_q holds the entry of root_reg.
            ST_WALK:
            begin
                if (mem_q.parent == root_reg)
                begin
                    if (which_reg)
                    begin
                        rank_b_next = mem_q.rank;
                    end
                    else
                    begin
                        rank_a_next = mem_q.rank;
                    end
                    cur_next = vtx;
                    if (vtx == root_reg)
                    begin
                        if (which_reg)
                        begin
                            state_next = ST_LINK;
                        end
                        else
                        begin
                            ra_next    = root_reg;
                            which_next = 1'b1;
                            state_next = ST_START;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = vtx;
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    root_next = mem_q.parent;
                    mem_re    = 1'b1;
                    mem_raddr = mem_q.parent;
                end
            end

            // mem_q holds the entry of cur_reg, which is not the root. Its
            // parent is never cur_reg, so the read and write never collide.
            ST_COMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = '{parent: root_reg, rank: mem_q.rank};
                if (mem_q.parent == root_reg)
                begin
                    if (which_reg)
                    begin
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        ra_next    = root_reg;
                        which_next = 1'b1;
                        state_next = ST_START;
                    end
                end
                else
                begin
                    cur_next  = mem_q.parent;
                    mem_re    = 1'b1;
                    mem_raddr = mem_q.parent;
                end
            end

            // root_reg is the root of the second endpoint here.
            ST_LINK:
            begin
                if (ra_reg == root_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    taken_next   = 1'b1;
                    hi_next      = swap ? root_reg : ra_reg;
                    rank_hi_next = swap ? rank_b_reg : rank_a_reg;
                    mem_we       = 1'b1;
                    mem_waddr    = swap ? ra_reg : root_reg;
                    mem_wdata    = '{parent: (swap ? root_reg : ra_reg),
                                     rank: (swap ? rank_a_reg : rank_b_reg)};
                    total_next   = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (rank_a_reg == rank_b_reg && rank_a_reg != RANK_MAX)
                    begin
                        state_next = ST_RANK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_RANK:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hi_reg;
                mem_wdata  = '{parent: hi_reg, rank: rank_hi_reg + 1'b1};
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_taken_next = taken_reg;
                    out_bad_next   = bad_reg;
                    out_total_next = total_reg;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A read never targets the entry being written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("table read collides with a write to the same entry");

    // An edge that is flagged never enters the tree.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> !(result_out.taken && result_out.bad_vertex))
        else $error("result is both taken and flagged");

    // The tree-edge count moves only on a link or on a restart.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == ST_LINK ||
                                 $past(state_reg) == ST_IDLE))
        else $error("tree-edge count changed outside a link or restart");

    // An accepted item always moves the engine out of the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (edge_in.valid && edge_in.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start processing");

endmodule
`default_nettype wire
